// ----- src/svm_pkg.sv -----
// Shared types and constants for the stack VM executor.
`timescale 1ns / 1ps
package svm_pkg;

    localparam logic [4:0] ACT_ADD      = 5'd0;
    localparam logic [4:0] ACT_SUB      = 5'd1;
    localparam logic [4:0] ACT_NEG      = 5'd2;
    localparam logic [4:0] ACT_EQ       = 5'd3;
    localparam logic [4:0] ACT_GT       = 5'd4;
    localparam logic [4:0] ACT_LT       = 5'd5;
    localparam logic [4:0] ACT_AND      = 5'd6;
    localparam logic [4:0] ACT_OR       = 5'd7;
    localparam logic [4:0] ACT_NOT      = 5'd8;
    localparam logic [4:0] ACT_POP      = 5'd9;
    localparam logic [4:0] ACT_PUSH     = 5'd10;
    localparam logic [4:0] ACT_LABEL    = 5'd11;
    localparam logic [4:0] ACT_GOTO     = 5'd12;
    localparam logic [4:0] ACT_IFGOTO   = 5'd13;
    localparam logic [4:0] ACT_FUNCTION = 5'd14;
    localparam logic [4:0] ACT_CALL     = 5'd15;
    localparam logic [4:0] ACT_RETURN   = 5'd16;
    localparam logic [4:0] ACT_SETKEY   = 5'd17;
    localparam logic [4:0] ACT_READ     = 5'd18;
    localparam logic [4:0] ACT_RESTART  = 5'd19;

    localparam logic [2:0] SEG_STATIC   = 3'd0;
    localparam logic [2:0] SEG_THIS     = 3'd1;
    localparam logic [2:0] SEG_LOCAL    = 3'd2;
    localparam logic [2:0] SEG_ARGUMENT = 3'd3;
    localparam logic [2:0] SEG_THAT     = 3'd4;
    localparam logic [2:0] SEG_CONSTANT = 3'd5;
    localparam logic [2:0] SEG_POINTER  = 3'd6;
    localparam logic [2:0] SEG_TEMP     = 3'd7;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_POPC  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    localparam logic [0:0] REG_PROGRAM_LENGTH = 1'b0;
    localparam logic [0:0] REG_ENTRY_POSITION = 1'b1;

    localparam logic [15:0] A_SP        = 16'd0;
    localparam logic [15:0] A_LCL       = 16'd1;
    localparam logic [15:0] A_ARG       = 16'd2;
    localparam logic [15:0] A_THIS      = 16'd3;
    localparam logic [15:0] A_THAT      = 16'd4;
    localparam logic [15:0] FRAME_WORDS = 16'd5;

    typedef struct packed {
        logic        en;
        logic        we;
        logic [15:0] addr;
        logic [15:0] wdata;
    } req_t;

endpackage

// ----- src/svm_ram.sv -----
// Data memory with address wrap and registered read.
`timescale 1ns / 1ps
module svm_ram #(
    parameter int MEM_WORDS = 32768
) (
    input  logic          clk,
    input  svm_pkg::req_t req,
    output logic [15:0]   rdata
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [15:0]   mem [MEM_WORDS];
    logic [AW-1:0] waddr;

    // address mod MEM_WORDS: quotient is below 64
    always_comb
    begin
        logic [22:0] r;
        r = {7'b0, req.addr};
        for (int k = 5; k >= 0; k--)
        begin
            if (r >= (23'(MEM_WORDS) << k))
            begin
                r = r - (23'(MEM_WORDS) << k);
            end
        end
        waddr = r[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[waddr] <= req.wdata;
            end
            else
            begin
                rdata <= mem[waddr];
            end
        end
    end

endmodule

// ----- src/stack_vm_executor.sv -----
// Stack VM executor: sequencer over a single-port data memory.
// Each memory read passes through S_WAIT; restart clears all MEM_WORDS words.
// One word in flight; the next word is accepted the cycle after the result is taken.
// Reset runs a clearing pass over all MEM_WORDS words; no word is accepted meanwhile.
`timescale 1ns / 1ps
module stack_vm_executor #(
    parameter int MEM_WORDS   = 32768,
    parameter int STACK_BASE  = 256,
    parameter int STATIC_BASE = 16,
    parameter int TEMP_BASE   = 5,
    parameter int KEY_ADDRESS = 24576
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [4:0]         action,
    input  logic [2:0]         segment,
    input  logic signed [15:0] operand,
    input  logic [15:0]        target,
    input  logic               halt_call,
    input  logic [14:0]        mem_address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        next_position,
    output logic               halted,
    output logic [1:0]         error_code,
    output logic signed [15:0] read_data
);

    typedef enum logic [5:0] {
        S_IDLE, S_DISPATCH, S_WAIT, S_CLEAR, S_FIN,
        S_AR_B, S_AR_A, S_AR_OP, S_AR_SP2, S_AR_DEC,
        S_PW_0, S_PW_1, S_PW_2, S_PW_3,
        S_SA_0, S_SA_1, S_PU_2, S_PU_3,
        S_PO_0, S_PO_1, S_PO_2, S_PO_3, S_PO_4,
        S_IG_1, S_IG_2, S_IG_3, S_FN_1,
        S_CL_1, S_CL_2, S_CL_3, S_CL_4, S_CL_5, S_CL_6,
        S_RT_1, S_RT_1B, S_RT_2, S_RT_3, S_RT_4, S_RT_5, S_RD_1
    } state_t;

    state_t        state_reg, state_next, wret_reg, wret_next, sret_reg, sret_next;
    logic [4:0]    act_reg, act_next;
    logic [2:0]    seg_reg, seg_next;
    logic [15:0]   opnd_reg, opnd_next, tgt_reg, tgt_next;
    logic          hlt_reg, hlt_next;
    logic [14:0]   maddr_reg, maddr_next;
    logic [15:0]   pos_reg, pos_next, plen_reg, plen_next, entry_reg, entry_next;
    logic [15:0]   npos_reg, npos_next, addr_reg, addr_next, frame_reg, frame_next;
    logic [15:0]   pv_reg, pv_next, cnt_reg, cnt_next;
    logic [2:0]    idx_reg, idx_next;
    logic          clr_fin_reg, clr_fin_next, halted_reg, halted_next;
    logic [1:0]    err_reg, err_next;
    logic [15:0]   rdw_reg, rdw_next;
    svm_pkg::req_t req_reg, req_next;
    logic          ov_reg, ov_next, oh_reg, oh_next;
    logic [15:0]   op_reg, op_next, ord_reg, ord_next;
    logic [1:0]    oe_reg, oe_next;
    logic [15:0]   d;

    svm_ram #(.MEM_WORDS(MEM_WORDS)) u_ram (.clk(clk), .req(req_reg), .rdata(d));

    function automatic svm_pkg::req_t rd(logic [15:0] a);
        svm_pkg::req_t r;
        r.en = 1'b1; r.we = 1'b0; r.addr = a; r.wdata = 16'd0;
        return r;
    endfunction

    function automatic svm_pkg::req_t wr(logic [15:0] a, logic [15:0] v);
        svm_pkg::req_t r;
        r.en = 1'b1; r.we = 1'b1; r.addr = a; r.wdata = v;
        return r;
    endfunction

    function automatic logic [15:0] alu(logic [4:0] op, logic [15:0] a, logic [15:0] b);
        logic [15:0] r;
        case (op)
            svm_pkg::ACT_ADD: r = a + b;
            svm_pkg::ACT_SUB: r = a - b;
            svm_pkg::ACT_NEG: r = 16'd0 - b;
            svm_pkg::ACT_EQ:  r = (a == b) ? 16'hFFFF : 16'd0;
            svm_pkg::ACT_GT:  r = ($signed(a) > $signed(b)) ? 16'hFFFF : 16'd0;
            svm_pkg::ACT_LT:  r = ($signed(a) < $signed(b)) ? 16'hFFFF : 16'd0;
            svm_pkg::ACT_AND: r = a & b;
            svm_pkg::ACT_OR:  r = a | b;
            default:          r = ~b;
        endcase
        return r;
    endfunction

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid     = ov_reg;
    assign next_position = op_reg;
    assign halted        = oh_reg;
    assign error_code    = oe_reg;
    assign read_data     = ord_reg;

    always_comb
    begin
        state_next = state_reg;   wret_next = wret_reg;   sret_next = sret_reg;
        act_next = act_reg;       seg_next = seg_reg;     opnd_next = opnd_reg;
        tgt_next = tgt_reg;       hlt_next = hlt_reg;     maddr_next = maddr_reg;
        pos_next = pos_reg;       plen_next = plen_reg;   entry_next = entry_reg;
        npos_next = npos_reg;     addr_next = addr_reg;   frame_next = frame_reg;
        pv_next = pv_reg;         cnt_next = cnt_reg;     idx_next = idx_reg;
        clr_fin_next = clr_fin_reg; halted_next = halted_reg; err_next = err_reg;
        rdw_next = rdw_reg;       req_next = '0;
        ov_next = ov_reg;         oh_next = oh_reg;       op_next = op_reg;
        ord_next = ord_reg;       oe_next = oe_reg;

        if (cfg_valid)
        begin
            if (cfg_index == svm_pkg::REG_PROGRAM_LENGTH)
            begin
                plen_next = cfg_data;
            end
            else
            begin
                entry_next = cfg_data;
            end
        end
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    act_next = action;  seg_next = segment;  opnd_next = operand;
                    tgt_next = target;  hlt_next = halt_call; maddr_next = mem_address;
                    halted_next = 1'b0; err_next = svm_pkg::ERR_NONE; rdw_next = 16'd0;
                    npos_next = pos_reg + 16'd1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (act_reg <= svm_pkg::ACT_RETURN && pos_reg >= plen_reg)
                begin
                    err_next = svm_pkg::ERR_RANGE; npos_next = pos_reg; state_next = S_FIN;
                end
                else if (act_reg <= svm_pkg::ACT_NOT)
                begin
                    req_next = rd(svm_pkg::A_SP); wret_next = S_AR_B; state_next = S_WAIT;
                end
                else
                begin
                    case (act_reg)
                        svm_pkg::ACT_POP:
                        begin
                            if (seg_reg == svm_pkg::SEG_CONSTANT)
                            begin
                                err_next = svm_pkg::ERR_POPC; npos_next = pos_reg;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_PO_0;
                            end
                        end
                        svm_pkg::ACT_PUSH:
                        begin
                            sret_next = S_PU_2; state_next = S_SA_0;
                        end
                        svm_pkg::ACT_LABEL:
                            state_next = S_FIN;
                        svm_pkg::ACT_GOTO:
                        begin
                            npos_next = tgt_reg; state_next = S_FIN;
                        end
                        svm_pkg::ACT_IFGOTO:
                        begin
                            req_next = rd(svm_pkg::A_SP); wret_next = S_IG_1;
                            state_next = S_WAIT;
                        end
                        svm_pkg::ACT_FUNCTION:
                        begin
                            cnt_next = opnd_reg[15] ? 16'd0 : {1'b0, opnd_reg[14:0]};
                            state_next = S_FN_1;
                        end
                        svm_pkg::ACT_CALL:
                        begin
                            pv_next = npos_reg; idx_next = 3'd1; sret_next = S_CL_1;
                            state_next = S_PW_0;
                        end
                        svm_pkg::ACT_RETURN:
                        begin
                            req_next = rd(svm_pkg::A_LCL); wret_next = S_RT_1;
                            state_next = S_WAIT;
                        end
                        svm_pkg::ACT_SETKEY:
                        begin
                            req_next = wr(16'(KEY_ADDRESS), opnd_reg); npos_next = pos_reg;
                            state_next = S_FIN;
                        end
                        svm_pkg::ACT_READ:
                        begin
                            req_next = rd({1'b0, maddr_reg}); npos_next = pos_reg;
                            wret_next = S_RD_1; state_next = S_WAIT;
                        end
                        svm_pkg::ACT_RESTART:
                        begin
                            cnt_next = 16'd0; clr_fin_next = 1'b1; npos_next = entry_reg;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            npos_next = pos_reg; state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_WAIT:
                state_next = wret_reg;
            S_CLEAR:
            begin
                req_next = wr(cnt_reg, (cnt_reg <= svm_pkg::A_LCL) ? 16'(STACK_BASE) : 16'd0);
                if (cnt_reg == 16'(MEM_WORDS - 1))
                begin
                    state_next = clr_fin_reg ? S_FIN : S_IDLE;
                    clr_fin_next = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + 16'd1;
                end
            end
            S_FIN:
            begin
                ov_next = 1'b1; op_next = npos_reg; oh_next = halted_reg;
                oe_next = err_reg; ord_next = rdw_reg; pos_next = npos_reg;
                state_next = S_IDLE;
            end
            S_AR_B:
            begin
                addr_next = d; req_next = rd(d - 16'd1); wret_next = S_AR_A;
                state_next = S_WAIT;
            end
            S_AR_A:
            begin
                pv_next = d;
                if (act_reg == svm_pkg::ACT_NEG || act_reg == svm_pkg::ACT_NOT)
                begin
                    req_next = wr(addr_reg - 16'd1, alu(act_reg, 16'd0, d));
                    state_next = S_FIN;
                end
                else
                begin
                    req_next = rd(addr_reg - 16'd2); wret_next = S_AR_OP;
                    state_next = S_WAIT;
                end
            end
            S_AR_OP:
            begin
                req_next = wr(addr_reg - 16'd2, alu(act_reg, d, pv_reg));
                state_next = S_AR_SP2;
            end
            S_AR_SP2:
            begin
                req_next = rd(svm_pkg::A_SP); wret_next = S_AR_DEC; state_next = S_WAIT;
            end
            S_AR_DEC:
            begin
                req_next = wr(svm_pkg::A_SP, d - 16'd1); state_next = S_FIN;
            end
            S_PW_0:
            begin
                req_next = rd(svm_pkg::A_SP); wret_next = S_PW_1; state_next = S_WAIT;
            end
            S_PW_1:
            begin
                req_next = wr(d, pv_reg); state_next = S_PW_2;
            end
            S_PW_2:
            begin
                req_next = rd(svm_pkg::A_SP); wret_next = S_PW_3; state_next = S_WAIT;
            end
            S_PW_3:
            begin
                req_next = wr(svm_pkg::A_SP, d + 16'd1); state_next = sret_reg;
            end
            S_SA_0:
            begin
                case (seg_reg)
                    svm_pkg::SEG_THIS:
                    begin
                        req_next = rd(svm_pkg::A_THIS); wret_next = S_SA_1;
                        state_next = S_WAIT;
                    end
                    svm_pkg::SEG_LOCAL:
                    begin
                        req_next = rd(svm_pkg::A_LCL); wret_next = S_SA_1;
                        state_next = S_WAIT;
                    end
                    svm_pkg::SEG_ARGUMENT:
                    begin
                        req_next = rd(svm_pkg::A_ARG); wret_next = S_SA_1;
                        state_next = S_WAIT;
                    end
                    svm_pkg::SEG_THAT:
                    begin
                        req_next = rd(svm_pkg::A_THAT); wret_next = S_SA_1;
                        state_next = S_WAIT;
                    end
                    svm_pkg::SEG_STATIC:
                    begin
                        addr_next = 16'(STATIC_BASE) + opnd_reg; state_next = sret_reg;
                    end
                    svm_pkg::SEG_POINTER:
                    begin
                        addr_next = svm_pkg::A_THIS + opnd_reg; state_next = sret_reg;
                    end
                    svm_pkg::SEG_TEMP:
                    begin
                        addr_next = 16'(TEMP_BASE) + opnd_reg; state_next = sret_reg;
                    end
                    default:
                    begin
                        addr_next = 16'd0; state_next = sret_reg;
                    end
                endcase
            end
            S_SA_1:
            begin
                addr_next = d + opnd_reg; state_next = sret_reg;
            end
            S_PU_2:
            begin
                if (seg_reg == svm_pkg::SEG_CONSTANT)
                begin
                    pv_next = opnd_reg; sret_next = S_FIN; state_next = S_PW_0;
                end
                else
                begin
                    req_next = rd(addr_reg); wret_next = S_PU_3; state_next = S_WAIT;
                end
            end
            S_PU_3:
            begin
                pv_next = d; sret_next = S_FIN; state_next = S_PW_0;
            end
            S_PO_0:
            begin
                req_next = rd(svm_pkg::A_SP); wret_next = S_PO_1; state_next = S_WAIT;
            end
            S_PO_1:
            begin
                req_next = wr(svm_pkg::A_SP, d - 16'd1); sret_next = S_PO_2;
                state_next = S_SA_0;
            end
            S_PO_2:
            begin
                req_next = rd(svm_pkg::A_SP); wret_next = S_PO_3; state_next = S_WAIT;
            end
            S_PO_3:
            begin
                req_next = rd(d); wret_next = S_PO_4; state_next = S_WAIT;
            end
            S_PO_4:
            begin
                req_next = wr(addr_reg, d);
                state_next = (act_reg == svm_pkg::ACT_RETURN) ? S_RT_2 : S_FIN;
            end
            S_IG_1:
            begin
                req_next = rd(d - 16'd1); wret_next = S_IG_2; state_next = S_WAIT;
            end
            S_IG_2:
            begin
                if (d != 16'd0)
                begin
                    npos_next = tgt_reg;
                end
                req_next = rd(svm_pkg::A_SP); wret_next = S_IG_3; state_next = S_WAIT;
            end
            S_IG_3:
            begin
                req_next = wr(svm_pkg::A_SP, d - 16'd1); state_next = S_FIN;
            end
            S_FN_1:
            begin
                if (cnt_reg == 16'd0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 16'd1; pv_next = 16'd0; sret_next = S_FN_1;
                    state_next = S_PW_0;
                end
            end
            S_CL_1:
            begin
                req_next = rd({13'd0, idx_reg}); wret_next = S_CL_2; state_next = S_WAIT;
            end
            S_CL_2:
            begin
                pv_next = d; idx_next = idx_reg + 3'd1;
                sret_next = (idx_reg == 3'd4) ? S_CL_3 : S_CL_1;
                state_next = S_PW_0;
            end
            S_CL_3:
            begin
                req_next = rd(svm_pkg::A_SP); wret_next = S_CL_4; state_next = S_WAIT;
            end
            S_CL_4:
            begin
                req_next = wr(svm_pkg::A_ARG, d - opnd_reg - svm_pkg::FRAME_WORDS);
                state_next = S_CL_5;
            end
            S_CL_5:
            begin
                req_next = rd(svm_pkg::A_SP); wret_next = S_CL_6; state_next = S_WAIT;
            end
            S_CL_6:
            begin
                req_next = wr(svm_pkg::A_LCL, d);
                if (hlt_reg)
                begin
                    halted_next = 1'b1; npos_next = pos_reg;
                end
                else
                begin
                    npos_next = tgt_reg;
                end
                state_next = S_FIN;
            end
            S_RT_1:
            begin
                frame_next = d; req_next = rd(d - svm_pkg::FRAME_WORDS);
                wret_next = S_RT_1B; state_next = S_WAIT;
            end
            S_RT_1B:
            begin
                npos_next = d; seg_next = svm_pkg::SEG_ARGUMENT; opnd_next = 16'd0;
                state_next = S_PO_0;
            end
            S_RT_2:
            begin
                req_next = rd(svm_pkg::A_ARG); wret_next = S_RT_3; state_next = S_WAIT;
            end
            S_RT_3:
            begin
                req_next = wr(svm_pkg::A_SP, d + 16'd1); idx_next = 3'd1;
                state_next = S_RT_4;
            end
            S_RT_4:
            begin
                req_next = rd(frame_reg - {13'd0, idx_reg}); wret_next = S_RT_5;
                state_next = S_WAIT;
            end
            S_RT_5:
            begin
                // frame-1..frame-4 restore THAT, THIS, ARG, LCL
                req_next = wr(svm_pkg::FRAME_WORDS - {13'd0, idx_reg}, d);
                idx_next = idx_reg + 3'd1;
                state_next = (idx_reg == 3'd4) ? S_FIN : S_RT_4;
            end
            S_RD_1:
            begin
                rdw_next = d; state_next = S_FIN;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            wret_reg    <= S_IDLE;
            sret_reg    <= S_IDLE;
            pos_reg     <= 16'd0;
            plen_reg    <= 16'd0;
            entry_reg   <= 16'd0;
            cnt_reg     <= 16'd0;
            clr_fin_reg <= 1'b0;
            req_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wret_reg    <= wret_next;
            sret_reg    <= sret_next;
            pos_reg     <= pos_next;
            plen_reg    <= plen_next;
            entry_reg   <= entry_next;
            cnt_reg     <= cnt_next;
            clr_fin_reg <= clr_fin_next;
            req_reg     <= req_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;    seg_reg    <= seg_next;    opnd_reg  <= opnd_next;
        tgt_reg    <= tgt_next;    hlt_reg    <= hlt_next;    maddr_reg <= maddr_next;
        npos_reg   <= npos_next;   addr_reg   <= addr_next;   frame_reg <= frame_next;
        pv_reg     <= pv_next;     idx_reg    <= idx_next;    halted_reg <= halted_next;
        err_reg    <= err_next;    rdw_reg    <= rdw_next;
        oh_reg     <= oh_next;     op_reg     <= op_next;     ord_reg   <= ord_next;
        oe_reg     <= oe_next;
    end

endmodule
